>>> rtl/g2s_pkg.sv
// g2s_pkg: widths, fixed-point constants and helper functions for the
// galactic to supergalactic rotation pipeline. No dependencies.
`default_nettype none
package g2s_pkg;

  localparam int AW   = 32;          // internal angle width, turn fraction
  localparam int CW   = 32;          // matrix coefficient width
  localparam int VF   = AW - 2;      // vector fraction bits
  localparam int CF   = CW - 2;      // coefficient fraction bits
  localparam int RW   = AW + 2;      // sin/cos datapath width
  localparam int XW   = AW + 4;      // atan2 datapath width
  localparam int PW   = 2 * XW;      // product width
  localparam int SHW  = $clog2(AW);  // CORDIC shift amount width
  localparam int NST  = 3 * AW + 8;  // pipeline registers ahead of the output

  localparam logic signed [XW-1:0] HALF_T    = XW'(1) <<< (AW - 1);
  localparam logic signed [XW-1:0] QUARTER_T = XW'(1) <<< (AW - 2);

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic signed [XW-1:0] aux;
    logic                 pole;
  } vec_t;

  // round(num * 2^bits / den) by restoring long division
  function automatic logic [63:0] frac_bits(logic [63:0] num, logic [63:0] den, int bits);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int k = 0; k < bits; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    r = r << 1;
    if (r >= den) q = q + 64'd1;
    return q;
  endfunction

  // floor(n / d), shift-subtract
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], n[k]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) / (2 pi) as an AW-bit turn fraction
  function automatic logic [AW-1:0] atan_entry(int i);
    logic [63:0]  c;
    logic [63:0]  a;
    logic [63:0]  t;
    logic [63:0]  term;
    logic [127:0] p;
    int           k;
    c = frac_bits(64'd159154943091895336, 64'd1000000000000000000, 63);
    if (i == 0) begin
      t = 64'd1 << 60;
    end else begin
      a = '0;
      k = 0;
      while (i * (2 * k + 1) < 64) begin
        term = udiv64(64'd1 << (64 - i * (2 * k + 1)), 64'(2 * k + 1));
        if ((k & 1) != 0) a = a - term;
        else a = a + term;
        k++;
      end
      p = {64'd0, a} * {64'd0, c};
      t = p[127:64];
    end
    t = (t + (64'd1 << (62 - AW))) >> (63 - AW);
    return t[AW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] coef_f(longint d);
    logic [63:0] m;
    m = frac_bits(64'(d < 0 ? -d : d), 64'd1000000000000, CF);
    return d < 0 ? -CW'(m) : CW'(m);
  endfunction

  localparam logic [63:0] KFIX64 =
    frac_bits(64'd607252935008881256, 64'd1000000000000000000, VF);
  localparam logic signed [XW-1:0] KFIX = XW'(KFIX64);

  localparam logic signed [CW-1:0] COEF [3][3] = '{
    '{coef_f(-64'sd735742574804), coef_f(64'sd677261296414), coef_f(64'sd0)},
    '{coef_f(-64'sd74553778365), coef_f(-64'sd80991471307), coef_f(64'sd993922590400)},
    '{coef_f(64'sd673145302109), coef_f(64'sd731271165817), coef_f(64'sd110081262225)}
  };

  // round(p / 2^sh), halves away from zero
  function automatic logic signed [PW-1:0] round_sh(logic signed [PW-1:0] p, int sh);
    logic signed [PW-1:0] h;
    logic signed [PW-1:0] a;
    h = PW'(1) <<< (sh - 1);
    if (p >= 0) begin
      return (p + h) >>> sh;
    end else begin
      a = -p;
      return -((a + h) >>> sh);
    end
  endfunction

  // fold an angle into +-quarter turn, seed the sin/cos CORDIC
  function automatic rot_t reduce(logic [AW-1:0] ang);
    rot_t r;
    logic signed [RW-1:0] s;
    s = RW'(signed'(ang));
    r.neg = 1'b0;
    if (s > RW'(QUARTER_T)) begin
      s = s - RW'(HALF_T);
      r.neg = 1'b1;
    end else if (s < -RW'(QUARTER_T)) begin
      s = s + RW'(HALF_T);
      r.neg = 1'b1;
    end
    r.x = RW'(KFIX);
    r.y = '0;
    r.z = s;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/g2s_in_if.sv
// g2s_in_if: input channel, galactic coordinate pair.
// No dependencies.
`default_nettype none
interface g2s_in_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          lon_in;
  logic signed [31:0]   lat_in;
  modport source(output valid, lon_in, lat_in, input ready);
  modport sink(input valid, lon_in, lat_in, output ready);
endinterface
`default_nettype wire

>>> rtl/g2s_out_if.sv
// g2s_out_if: result channel, supergalactic coordinate pair.
// No dependencies.
`default_nettype none
interface g2s_out_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          lon_out;
  logic signed [31:0]   lat_out;
  modport source(output valid, lon_out, lat_out, input ready);
  modport sink(input valid, lon_out, lat_out, output ready);
endinterface
`default_nettype wire

>>> rtl/g2s_rot_cell.sv
// g2s_rot_cell: one rotation-mode CORDIC micro-rotation, registered.
// Depends on g2s_pkg.
`default_nettype none
module g2s_rot_cell (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [g2s_pkg::SHW-1:0]  shift_i,
  input  wire logic [g2s_pkg::AW-1:0]   atan_i,
  input  wire g2s_pkg::rot_t            d_i,
  output g2s_pkg::rot_t                 d_o
);
  logic signed [g2s_pkg::RW-1:0] dx, dy, at;
  g2s_pkg::rot_t d_nxt;

  always_comb begin
    dx = d_i.y >>> shift_i;
    dy = d_i.x >>> shift_i;
    at = g2s_pkg::RW'(atan_i);
    d_nxt = d_i;
    if (d_i.z >= 0) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_o <= d_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/g2s_vec_cell.sv
// g2s_vec_cell: one vectoring-mode CORDIC step (atan2), registered.
// Depends on g2s_pkg.
`default_nettype none
module g2s_vec_cell (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [g2s_pkg::SHW-1:0]  shift_i,
  input  wire logic [g2s_pkg::AW-1:0]   atan_i,
  input  wire g2s_pkg::vec_t            d_i,
  output g2s_pkg::vec_t                 d_o
);
  logic signed [g2s_pkg::XW-1:0] dx, dy, at;
  g2s_pkg::vec_t d_nxt;

  always_comb begin
    dx = d_i.y >>> shift_i;
    dy = d_i.x >>> shift_i;
    at = g2s_pkg::XW'(atan_i);
    d_nxt = d_i;
    if (d_i.y > 0) begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end else begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_o <= d_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/galactic_to_supergalactic_rotation_core.sv
// galactic_to_supergalactic_rotation_core: top level of the coordinate rotation pipeline.
// Depends on g2s_pkg, g2s_in_if, g2s_out_if, g2s_rot_cell, g2s_vec_cell.
//
//   channel   dir  payload                       role
//   in_chan   in   lon_in[31:0], lat_in[31:0]s   galactic direction, turn fractions
//   out_chan  out  lon_out[31:0], lat_out[31:0]s supergalactic direction
//
// One transfer per cycle in, one per cycle out, while the output is taken. The pipe
// holds AW sin/cos cells, AW cells each for the two atan2 passes,
// plus the multiply, reduction and output registers.
// Synchronous active-low reset clears the valid line only; payload is not reset.
// The whole pipe stalls as one when the output register holds an untaken result.
`default_nettype none
module galactic_to_supergalactic_rotation_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  g2s_in_if.sink     in_chan,
  g2s_out_if.source  out_chan
);
  localparam int AW = g2s_pkg::AW;
  localparam int XW = g2s_pkg::XW;
  localparam int RW = g2s_pkg::RW;
  localparam int PW = g2s_pkg::PW;

  logic adv;
  logic [g2s_pkg::NST-1:0] vld_r;
  logic out_vld_r;
  logic [31:0] out_lon_r;
  logic signed [31:0] out_lat_r;

  // whole pipe moves unless the output is full and not taken
  assign adv = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign out_chan.valid = out_vld_r;
  assign out_chan.lon_out = out_lon_r;
  assign out_chan.lat_out = out_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[g2s_pkg::NST-2:0], in_chan.valid};
      out_vld_r <= vld_r[g2s_pkg::NST-1];
    end
  end

  // ---- sin/cos of longitude and latitude, two lanes in lockstep
  g2s_pkg::rot_t lon_c [AW+1];
  g2s_pkg::rot_t lat_c [AW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_c[0] <= g2s_pkg::reduce(in_chan.lon_in);
      lat_c[0] <= g2s_pkg::reduce(in_chan.lat_in);
    end
  end

  for (genvar i = 0; i < AW; i++) begin : g_rot
    localparam logic [AW-1:0] ATAN_I = g2s_pkg::atan_entry(i);
    g2s_rot_cell u_lon (.clk(clk), .en(adv), .shift_i(g2s_pkg::SHW'(i)),
                        .atan_i(ATAN_I), .d_i(lon_c[i]), .d_o(lon_c[i+1]));
    g2s_rot_cell u_lat (.clk(clk), .en(adv), .shift_i(g2s_pkg::SHW'(i)),
                        .atan_i(ATAN_I), .d_i(lat_c[i]), .d_o(lat_c[i+1]));
  end

  // undo the half-turn fold
  logic signed [RW-1:0] cl, sl, cb, sb;
  always_comb begin
    cl = lon_c[AW].neg ? -lon_c[AW].x : lon_c[AW].x;
    sl = lon_c[AW].neg ? -lon_c[AW].y : lon_c[AW].y;
    cb = lat_c[AW].neg ? -lat_c[AW].x : lat_c[AW].x;
    sb = lat_c[AW].neg ? -lat_c[AW].y : lat_c[AW].y;
  end

  // ---- unit vector: cos b cos l, cos b sin l, sin b
  logic signed [PW-1:0] p_cc_r, p_cs_r;
  logic signed [RW-1:0] sb_r;
  logic signed [RW-1:0] v1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc_r <= PW'(cb) * PW'(cl);
      p_cs_r <= PW'(cb) * PW'(sl);
      sb_r   <= sb;
      v1_r[0] <= RW'(g2s_pkg::round_sh(p_cc_r, g2s_pkg::VF));
      v1_r[1] <= RW'(g2s_pkg::round_sh(p_cs_r, g2s_pkg::VF));
      v1_r[2] <= sb_r;
    end
  end

  // ---- 3x3 rotation: products, then rounded row sums
  logic signed [PW-1:0] pr_r [3][3];
  logic signed [XW-1:0] v2_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          pr_r[r][k] <= PW'(g2s_pkg::COEF[r][k]) * PW'(v1_r[k]);
        end
        v2_r[r] <= XW'(g2s_pkg::round_sh(pr_r[r][0], g2s_pkg::CF)
                     + g2s_pkg::round_sh(pr_r[r][1], g2s_pkg::CF)
                     + g2s_pkg::round_sh(pr_r[r][2], g2s_pkg::CF));
      end
    end
  end

  // ---- longitude: atan2(v2y, v2x); vertical part rides in aux
  g2s_pkg::vec_t va [AW+1];
  g2s_pkg::vec_t va_nxt;

  always_comb begin
    va_nxt.pole = (v2_r[0] == '0) && (v2_r[1] == '0);
    va_nxt.aux  = v2_r[2];
    if (v2_r[0] < 0) begin
      va_nxt.x = -v2_r[0];
      va_nxt.y = -v2_r[1];
      va_nxt.z = g2s_pkg::HALF_T;
    end else begin
      va_nxt.x = v2_r[0];
      va_nxt.y = v2_r[1];
      va_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) va[0] <= va_nxt;
  end

  for (genvar i = 0; i < AW; i++) begin : g_veca
    localparam logic [AW-1:0] ATAN_I = g2s_pkg::atan_entry(i);
    g2s_vec_cell u_cell (.clk(clk), .en(adv), .shift_i(g2s_pkg::SHW'(i)),
                         .atan_i(ATAN_I), .d_i(va[i]), .d_o(va[i+1]));
  end

  // ---- gain-correct the horizontal length
  logic signed [PW-1:0] pm_r;
  logic [AW-1:0]        lo_r;
  logic signed [XW-1:0] vz_r;
  logic                 pole_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pm_r   <= PW'(va[AW].x) * PW'(g2s_pkg::KFIX);
      lo_r   <= va[AW].z[AW-1:0];
      vz_r   <= va[AW].aux;
      pole_r <= va[AW].pole;
    end
  end

  // ---- latitude: atan2(v2z, rk); aux now carries the output longitude,
  // or the pole latitude when the horizontal part vanished
  g2s_pkg::vec_t vb [AW+1];
  g2s_pkg::vec_t vb_nxt;
  logic signed [XW-1:0] rk;

  always_comb begin
    rk = XW'(g2s_pkg::round_sh(pm_r, g2s_pkg::VF));
    vb_nxt.pole = pole_r;
    if (pole_r) begin
      if (vz_r > 0) vb_nxt.aux = g2s_pkg::QUARTER_T;
      else if (vz_r < 0) vb_nxt.aux = -g2s_pkg::QUARTER_T;
      else vb_nxt.aux = '0;
    end else begin
      vb_nxt.aux = XW'(lo_r);
    end
    if (rk < 0) begin
      vb_nxt.x = -rk;
      vb_nxt.y = -vz_r;
      vb_nxt.z = g2s_pkg::HALF_T;
    end else begin
      vb_nxt.x = rk;
      vb_nxt.y = vz_r;
      vb_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) vb[0] <= vb_nxt;
  end

  for (genvar i = 0; i < AW; i++) begin : g_vecb
    localparam logic [AW-1:0] ATAN_I = g2s_pkg::atan_entry(i);
    g2s_vec_cell u_cell (.clk(clk), .en(adv), .shift_i(g2s_pkg::SHW'(i)),
                         .atan_i(ATAN_I), .d_i(vb[i]), .d_o(vb[i+1]));
  end

  // ---- clamp to +-90 degrees, pole override, output register
  logic signed [XW-1:0] la;
  logic [31:0]          lon_nxt;
  logic signed [31:0]   lat_nxt;

  always_comb begin
    la = vb[AW].z;
    if (la > g2s_pkg::QUARTER_T) la = g2s_pkg::QUARTER_T;
    if (la < -g2s_pkg::QUARTER_T) la = -g2s_pkg::QUARTER_T;
    if (vb[AW].pole) begin
      lon_nxt = '0;
      lat_nxt = vb[AW].aux[31:0];
    end else begin
      lon_nxt = vb[AW].aux[31:0];
      lat_nxt = la[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lon_r <= lon_nxt;
      out_lat_r <= lat_nxt;
    end
  end
endmodule
`default_nettype wire
